[design/gcdlcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdlcm_pkg
// Shared types and constants for the GCD / LCM unit: controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package gcdlcm_pkg;

    localparam int unsigned OPND_W = 32;
    localparam int unsigned LCM_W  = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;       // capture operands, clear the shift count
        logic gcd_step;   // one binary GCD step
        logic start_div;  // latch the divisor and set up the quotient divider
        logic div_step;   // one restoring division step
        logic mul;        // multiply quotient by second operand
        logic load_out;   // copy results into the output register
    } cmd_t;

    typedef struct packed {
        logic gcd_done;   // one working operand has reached zero
        logic nonzero;    // both operands of the item are nonzero
        logic div_last;   // the current division step is the final one
    } status_t;

endpackage

[design/gcdlcm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdlcm_ctrl
// Sequencer for the GCD / LCM unit: handshakes and command generation.
// ----------------------------------------------------------------------------
module gcdlcm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  gcdlcm_pkg::status_t status,
    output gcdlcm_pkg::cmd_t    cmd
);

    gcdlcm_pkg::state_t state_reg;
    gcdlcm_pkg::state_t state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == gcdlcm_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcdlcm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            gcdlcm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = gcdlcm_pkg::ST_GCD;
                end
            end
            gcdlcm_pkg::ST_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = status.nonzero ? gcdlcm_pkg::ST_DIV : gcdlcm_pkg::ST_DONE;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            gcdlcm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = gcdlcm_pkg::ST_MUL;
                end
            end
            gcdlcm_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = gcdlcm_pkg::ST_DONE;
            end
            gcdlcm_pkg::ST_DONE:
            begin
                // Wait until the output register is empty or drains this cycle.
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = gcdlcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gcdlcm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/gcdlcm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdlcm_dp
// Datapath: binary GCD, restoring divider for a / gcd, one multiplier for
// the multiple, and the output register.
// ----------------------------------------------------------------------------
module gcdlcm_dp
#(
    parameter int unsigned WIDTH = 32
)
(
    input  logic                                clk,
    input  logic [gcdlcm_pkg::OPND_W-1:0]       first_operand,
    input  logic [gcdlcm_pkg::OPND_W-1:0]       second_operand,
    input  gcdlcm_pkg::cmd_t                    cmd,
    output gcdlcm_pkg::status_t                 status,
    output logic [gcdlcm_pkg::OPND_W-1:0]       gcd_value,
    output logic [gcdlcm_pkg::LCM_W-1:0]        lcm_value,
    output logic                                both_zero
);

    localparam int unsigned KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]   x_reg;
    logic [WIDTH-1:0]   y_reg;
    logic [WIDTH-1:0]   a_reg;
    logic [WIDTH-1:0]   b_reg;
    logic [KW-1:0]      k_reg;
    logic               nz_reg;
    logic               bz_reg;
    logic [WIDTH-1:0]   g_reg;
    logic [WIDTH-1:0]   rem_reg;
    logic [WIDTH-1:0]   quo_reg;
    logic [CW-1:0]      cnt_reg;
    logic [2*WIDTH-1:0] prod_reg;
    logic [gcdlcm_pkg::OPND_W-1:0] gcd_out_reg;
    logic [gcdlcm_pkg::LCM_W-1:0]  lcm_out_reg;
    logic                          bz_out_reg;

    logic [WIDTH-1:0]   g_next;
    logic [WIDTH:0]     trial;
    logic [WIDTH:0]     diff;

    // The loop leaves one operand at zero; the other carries the odd part.
    assign g_next = (x_reg | y_reg) << k_reg;
    assign trial  = {rem_reg, quo_reg[WIDTH-1]};
    assign diff   = trial - {1'b0, g_reg};

    assign status.gcd_done = (x_reg == '0) || (y_reg == '0);
    assign status.nonzero  = nz_reg;
    assign status.div_last = (cnt_reg == CW'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg  <= first_operand[WIDTH-1:0];
            y_reg  <= second_operand[WIDTH-1:0];
            a_reg  <= first_operand[WIDTH-1:0];
            b_reg  <= second_operand[WIDTH-1:0];
            k_reg  <= '0;
            nz_reg <= (first_operand[WIDTH-1:0] != '0) && (second_operand[WIDTH-1:0] != '0);
            bz_reg <= (first_operand[WIDTH-1:0] == '0) && (second_operand[WIDTH-1:0] == '0);
        end
        else if (cmd.gcd_step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end
            else if (!x_reg[0])
            begin
                x_reg <= x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_reg <= y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_reg <= x_reg - y_reg;
            end
            else
            begin
                y_reg <= y_reg - x_reg;
            end
        end

        if (cmd.start_div)
        begin
            g_reg   <= g_next;
            rem_reg <= '0;
            quo_reg <= a_reg;
            cnt_reg <= CW'(WIDTH);
        end
        else if (cmd.div_step)
        begin
            // Quotient bits shift in where the dividend bits shift out.
            if (!diff[WIDTH])
            begin
                rem_reg <= diff[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CW'(1);
        end

        if (cmd.mul)
        begin
            prod_reg <= quo_reg * b_reg;
        end

        if (cmd.load_out)
        begin
            gcd_out_reg <= gcdlcm_pkg::OPND_W'(g_reg);
            lcm_out_reg <= nz_reg ? gcdlcm_pkg::LCM_W'(prod_reg) : '0;
            bz_out_reg  <= bz_reg;
        end
    end

    assign gcd_value = gcd_out_reg;
    assign lcm_value = lcm_out_reg;
    assign both_zero = bz_out_reg;

endmodule

[design/gcd_lcm_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_unit_core
// Greatest common divisor and least common multiple of two unsigned operands.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------
//  in      | in_valid / in_ready  | first_operand, second_operand
//  out     | out_valid / out_ready| gcd_value, lcm_value, both_zero
//
//  One beat in is captured, runs binary GCD steps, latches the divisor as
//  the GCD loop ends, runs WIDTH restoring divider steps and a multiply
//  (both skipped when an operand is zero), then loads the output register.
//  The GCD loop and the one-bit-per-cycle divider set how long a beat takes.
//  A new beat is taken once the previous result sits in the output register.
//  Reset clears the sequencer and the output valid flag only.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_core
#(
    parameter int unsigned WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [gcdlcm_pkg::OPND_W-1:0]     first_operand,
    input  logic [gcdlcm_pkg::OPND_W-1:0]     second_operand,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [gcdlcm_pkg::OPND_W-1:0]     gcd_value,
    output logic [gcdlcm_pkg::LCM_W-1:0]      lcm_value,
    output logic                              both_zero
);

    gcdlcm_pkg::cmd_t    cmd;
    gcdlcm_pkg::status_t status;

    gcdlcm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gcdlcm_dp #(.WIDTH(WIDTH)) u_dp
    (
        .clk            (clk),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .cmd            (cmd),
        .status         (status),
        .gcd_value      (gcd_value),
        .lcm_value      (lcm_value),
        .both_zero      (both_zero)
    );

    // A captured beat keeps the input side closed on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && both_zero) |-> (gcd_value == '0 && lcm_value == '0))
        else $error("both-zero result carries nonzero values");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gcd_value == '0) |-> both_zero)
        else $error("zero divisor without both-zero flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && lcm_value != '0) |-> (gcd_value != '0))
        else $error("nonzero multiple with zero divisor");

endmodule
